>>> rtl/core/psp_pkg.sv
// Package with types, codes and defaults shared by the format specifier parser.
package psp_pkg;

    localparam int NUM_BITS_DEFAULT = 31;
    localparam int OUT_ACC_BITS     = 31;

    typedef enum logic [2:0] {
        PH_FLAGS     = 3'd0,
        PH_WIDTH     = 3'd1,
        PH_WIDTH_DIG = 3'd2,
        PH_PREC_DOT  = 3'd3,
        PH_PREC_DIG  = 3'd4,
        PH_LEN_H     = 3'd5,
        PH_LEN_L     = 3'd6,
        PH_LEN_DONE  = 3'd7
    } phase_t;

    typedef enum logic [2:0] {
        LEN_NONE = 3'd0,
        LEN_HH   = 3'd1,
        LEN_H    = 3'd2,
        LEN_L    = 3'd3,
        LEN_LL   = 3'd4,
        LEN_J    = 3'd5,
        LEN_Z    = 3'd6,
        LEN_BIGL = 3'd7
    } length_t;

    // Flag bit positions.
    localparam int FB_HASH  = 0;
    localparam int FB_ZERO  = 1;
    localparam int FB_DASH  = 2;
    localparam int FB_SPACE = 3;
    localparam int FB_PLUS  = 4;

    // Given bit positions.
    localparam int GB_WIDTH = 0;
    localparam int GB_PREC  = 1;

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_LOW_H = 8'h68;
    localparam logic [7:0] CH_LOW_L = 8'h6C;
    localparam logic [7:0] CH_LOW_J = 8'h6A;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;
    localparam logic [7:0] CH_UP_L  = 8'h4C;

    typedef struct packed {
        logic               start_spec;
        logic [7:0]         spec_char;
        logic signed [31:0] star_value;
    } spec_in_t;

    typedef struct packed {
        logic        alt_form;
        logic        zero_pad;
        logic        left_align;
        logic        space_sign;
        logic        plus_sign;
        logic        width_given;
        logic [30:0] field_width;
        logic        prec_given;
        logic [30:0] prec_value;
        logic [2:0]  length_code;
        logic [7:0]  stop_char;
    } spec_out_t;

    // Control state carried from one character to the next.
    typedef struct packed {
        phase_t     phase;
        logic [4:0] flag_bits;
        logic [1:0] given_bits;
        length_t    length_reg;
    } ctl_state_t;

endpackage

>>> rtl/core/printf_spec_parser.sv
// Top level of the printf format specifier parser, one character per transaction.
//
//  Channel   Direction  Handshake                  Payload
//  char      in         char_valid / char_ready    char_item   (spec_in_t)
//  result    out        result_valid / result_ready result_item (spec_out_t)
//
// The decode and the multiply-by-ten accumulate run on the character in the input
// register; its result, if any, is loaded into the output register as the character
// leaves it. One character is taken per cycle at full rate.
// The input register drains only when the output register is free or the
// character produces no result, so a stalled result stops the stream there.
// Reset clears the parser state to the flags phase and drops both valid bits.
module printf_spec_parser
    import psp_pkg::*;
#(
    parameter int NUM_BITS = NUM_BITS_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      char_valid,
    output logic      char_ready,
    input  spec_in_t  char_item,
    output logic      result_valid,
    input  logic      result_ready,
    output spec_out_t result_item
);

    localparam int MUL_BITS = NUM_BITS + 4;
    localparam logic [NUM_BITS-1:0] ACC_MAX = {NUM_BITS{1'b1}};

    localparam ctl_state_t CTL_CLEAR = '{
        phase:      PH_FLAGS,
        flag_bits:  5'd0,
        given_bits: 2'd0,
        length_reg: LEN_NONE
    };

    spec_in_t            item_reg;
    logic                item_valid_reg;
    ctl_state_t          ctl_reg, ctl_next;
    logic [NUM_BITS-1:0] width_reg, width_next;
    logic [NUM_BITS-1:0] prec_reg, prec_next;
    spec_out_t           result_reg, result_next;
    logic                result_valid_reg;

    logic                emit;
    logic                fire;
    logic                out_free;

    // Per-character decode, all in one pass over the registered character.
    always_comb
    begin
        ctl_state_t          cur;
        logic [NUM_BITS-1:0] wacc;
        logic [NUM_BITS-1:0] pacc;
        logic [7:0]          ch;
        logic                neg;
        logic [31:0]         mag;
        logic [NUM_BITS-1:0] mag_sat;
        logic                is_dig;
        logic [3:0]          dval;
        logic [MUL_BITS-1:0] wmul;
        logic [MUL_BITS-1:0] pmul;
        logic [NUM_BITS-1:0] wdig;
        logic [NUM_BITS-1:0] pdig;
        logic                handled;

        ch     = item_reg.spec_char;
        neg    = item_reg.star_value[31];
        mag    = neg ? (~item_reg.star_value + 32'd1) : item_reg.star_value;
        is_dig = ch inside {[CH_ZERO:CH_NINE]};
        dval   = 4'(ch - CH_ZERO);

        if (item_reg.start_spec)
        begin
            cur  = CTL_CLEAR;
            wacc = '0;
            pacc = '0;
        end
        else
        begin
            cur  = ctl_reg;
            wacc = width_reg;
            pacc = prec_reg;
        end

        if (NUM_BITS < 32 && (mag >> NUM_BITS) != 32'd0)
            mag_sat = ACC_MAX;
        else
            mag_sat = NUM_BITS'(mag);

        // A width digit right after a star restarts the width from zero.
        wmul = (cur.phase == PH_WIDTH) ? MUL_BITS'(dval)
             : MUL_BITS'(wacc) * MUL_BITS'(10) + MUL_BITS'(dval);
        pmul = MUL_BITS'(pacc) * MUL_BITS'(10) + MUL_BITS'(dval);
        wdig = (wmul[MUL_BITS-1:NUM_BITS] != '0) ? ACC_MAX : wmul[NUM_BITS-1:0];
        pdig = (pmul[MUL_BITS-1:NUM_BITS] != '0) ? ACC_MAX : pmul[NUM_BITS-1:0];

        ctl_next   = cur;
        width_next = wacc;
        prec_next  = pacc;
        emit       = 1'b0;
        handled    = 1'b0;

        if (cur.phase == PH_LEN_H || cur.phase == PH_LEN_L)
        begin
            handled = 1'b1;
            if (cur.phase == PH_LEN_H && ch == CH_LOW_H)
            begin
                ctl_next.length_reg = LEN_HH;
                ctl_next.phase      = PH_LEN_DONE;
            end
            else if (cur.phase == PH_LEN_L && ch == CH_LOW_L)
            begin
                ctl_next.length_reg = LEN_LL;
                ctl_next.phase      = PH_LEN_DONE;
            end
            else
            begin
                ctl_next.length_reg = (cur.phase == PH_LEN_H) ? LEN_H : LEN_L;
                emit = 1'b1;
            end
        end
        else if (cur.phase == PH_LEN_DONE)
        begin
            handled = 1'b1;
            emit    = 1'b1;
        end

        if (!handled && cur.phase == PH_FLAGS)
        begin
            handled = 1'b1;
            case (ch)
                CH_HASH:  ctl_next.flag_bits[FB_HASH]  = 1'b1;
                CH_ZERO:  ctl_next.flag_bits[FB_ZERO]  = 1'b1;
                CH_DASH:  ctl_next.flag_bits[FB_DASH]  = 1'b1;
                CH_SPACE: ctl_next.flag_bits[FB_SPACE] = 1'b1;
                CH_PLUS:  ctl_next.flag_bits[FB_PLUS]  = 1'b1;
                default:
                begin
                    handled        = 1'b0;
                    ctl_next.phase = PH_WIDTH;
                end
            endcase
            if (handled && ctl_next.flag_bits[FB_DASH])
                ctl_next.flag_bits[FB_ZERO] = 1'b0;
        end

        if (!handled && (ctl_next.phase == PH_WIDTH || ctl_next.phase == PH_WIDTH_DIG))
        begin
            if (ch == CH_STAR)
            begin
                handled = 1'b1;
                if (neg)
                    ctl_next.flag_bits[FB_DASH] = 1'b1;
                width_next                    = mag_sat;
                ctl_next.given_bits[GB_WIDTH] = 1'b1;
                ctl_next.phase                = PH_WIDTH;
            end
            else if (is_dig)
            begin
                handled                       = 1'b1;
                width_next                    = wdig;
                ctl_next.given_bits[GB_WIDTH] = 1'b1;
                ctl_next.phase                = PH_WIDTH_DIG;
            end
            else if (ch == CH_DOT)
            begin
                handled                      = 1'b1;
                ctl_next.given_bits[GB_PREC] = 1'b1;
                prec_next                    = '0;
                ctl_next.phase               = PH_PREC_DOT;
            end
        end
        else if (!handled &&
                 (ctl_next.phase == PH_PREC_DOT || ctl_next.phase == PH_PREC_DIG))
        begin
            if (ctl_next.phase == PH_PREC_DOT && ch == CH_STAR)
            begin
                handled = 1'b1;
                if (neg)
                    ctl_next.given_bits[GB_PREC] = 1'b0;
                else
                    prec_next = mag_sat;
                ctl_next.phase = PH_PREC_DIG;
            end
            else if (is_dig)
            begin
                handled        = 1'b1;
                prec_next      = pdig;
                ctl_next.phase = PH_PREC_DIG;
            end
        end

        if (!handled)
        begin
            case (ch)
                CH_LOW_H: ctl_next.phase = PH_LEN_H;
                CH_LOW_L: ctl_next.phase = PH_LEN_L;
                CH_LOW_J:
                begin
                    ctl_next.length_reg = LEN_J;
                    ctl_next.phase      = PH_LEN_DONE;
                end
                CH_LOW_Z:
                begin
                    ctl_next.length_reg = LEN_Z;
                    ctl_next.phase      = PH_LEN_DONE;
                end
                CH_UP_L:
                begin
                    ctl_next.length_reg = LEN_BIGL;
                    ctl_next.phase      = PH_LEN_DONE;
                end
                default: emit = 1'b1;
            endcase
        end

        result_next.alt_form    = ctl_next.flag_bits[FB_HASH];
        result_next.zero_pad    = ctl_next.flag_bits[FB_ZERO];
        result_next.left_align  = ctl_next.flag_bits[FB_DASH];
        result_next.space_sign  = ctl_next.flag_bits[FB_SPACE];
        result_next.plus_sign   = ctl_next.flag_bits[FB_PLUS];
        result_next.width_given = ctl_next.given_bits[GB_WIDTH];
        result_next.field_width = OUT_ACC_BITS'(width_next);
        result_next.prec_given  = ctl_next.given_bits[GB_PREC];
        result_next.prec_value  = OUT_ACC_BITS'(prec_next);
        result_next.length_code = ctl_next.length_reg;
        result_next.stop_char   = ch;

        // A finished specification leaves the parser as after reset.
        if (emit)
        begin
            ctl_next   = CTL_CLEAR;
            width_next = '0;
            prec_next  = '0;
        end
    end

    assign out_free   = !result_valid_reg || result_ready;
    assign fire       = item_valid_reg && (!emit || out_free);
    assign char_ready = !item_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            ctl_reg          <= CTL_CLEAR;
            width_reg        <= '0;
            prec_reg         <= '0;
        end
        else
        begin
            if (char_ready)
                item_valid_reg <= char_valid;
            if (fire)
            begin
                ctl_reg   <= ctl_next;
                width_reg <= width_next;
                prec_reg  <= prec_next;
            end
            if (fire && emit)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_valid && char_ready)
            item_reg <= char_item;
        if (fire && emit)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result_item  = result_reg;

endmodule

>>> rtl/core/psp_checker.sv
// Port-level checker for the format specifier parser and its bind statement.
module psp_checker
    import psp_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      char_ready,
    input logic      result_valid,
    input logic      result_ready,
    input spec_out_t result_item
);

    // A stalled result transaction keeps its payload.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_item))
        else $error("result changed while stalled");

    // With no result waiting, a character is always taken.
    a_ready_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> char_ready)
        else $error("input stalled with no result waiting");

    // A width value only exists together with its given bit.
    a_width_given: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_item.width_given |-> result_item.field_width == 31'd0)
        else $error("field width without width_given");

    // Without a length modifier, a length letter would have been consumed.
    a_no_len_letter: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_item.length_code == LEN_NONE |->
            !(result_item.stop_char == CH_LOW_H || result_item.stop_char == CH_LOW_L ||
              result_item.stop_char == CH_LOW_J || result_item.stop_char == CH_LOW_Z ||
              result_item.stop_char == CH_UP_L))
        else $error("length letter ended a spec without length");

    // Digits are always consumed outside the length phases.
    a_no_digit_stop: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_item.length_code == LEN_NONE |->
            !(result_item.stop_char >= CH_ZERO && result_item.stop_char <= CH_NINE))
        else $error("digit ended a spec without length");

endmodule

bind printf_spec_parser psp_checker u_psp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .char_ready   (char_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
);

>>> test/tb.sv
// Self-checking testbench for the printf format specifier parser.
`timescale 1ns / 100ps

module tb;
    import psp_pkg::*;

    localparam int ACC_BITS = NUM_BITS_DEFAULT;
    localparam longint unsigned ACC_MAX = (64'd1 << ACC_BITS) - 64'd1;
    localparam int N_DIR = 25;
    localparam int N_RANDOM = 1400;
    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_AT = 800;
    localparam int HOLD_LEN = 400;

    localparam logic [4:0] M_HASH  = 5'(1 << FB_HASH);
    localparam logic [4:0] M_ZERO  = 5'(1 << FB_ZERO);
    localparam logic [4:0] M_DASH  = 5'(1 << FB_DASH);
    localparam logic [4:0] M_SPACE = 5'(1 << FB_SPACE);
    localparam logic [4:0] M_PLUS  = 5'(1 << FB_PLUS);
    localparam logic [1:0] G_WIDTH = 2'(1 << GB_WIDTH);
    localparam logic [1:0] G_PREC  = 2'(1 << GB_PREC);

    typedef struct packed {
        spec_in_t  item;
        logic      typed;
        spec_out_t want;
    } dir_row_t;

    logic      clk;
    logic      rst_n;
    logic      char_valid;
    logic      char_ready;
    spec_in_t  char_item;
    logic      result_valid;
    logic      result_ready;
    spec_out_t result_item;

    printf_spec_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_ready   (char_ready),
        .char_item    (char_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item)
    );

    // Parser state as the testbench tracks it.
    phase_t          ps_phase;
    logic [4:0]      ps_flags;
    longint unsigned ps_width;
    longint unsigned ps_prec;
    logic [1:0]      ps_given;
    length_t         ps_len;

    spec_out_t   parsed_specs_q [$];
    logic [7:0]  spec_bytes [$];
    dir_row_t    dir_rows [N_DIR];
    logic [7:0]  flag_chars [5] = '{CH_HASH, CH_ZERO, CH_DASH, CH_SPACE, CH_PLUS};
    string       conv_chars = "diouxXcspnfeEgGaA%";
    int          n_mismatch = 0;
    int          n_sent = 0;
    int          burst_left;
    int          cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void clear_parser();
        ps_phase = PH_FLAGS;
        ps_flags = '0;
        ps_width = 0;
        ps_prec  = 0;
        ps_given = '0;
        ps_len   = LEN_NONE;
    endfunction

    function automatic longint unsigned add_digit(longint unsigned acc, logic [7:0] c);
        longint unsigned v;
        v = acc * 64'd10 + 64'(c - CH_ZERO);
        return (v > ACC_MAX) ? ACC_MAX : v;
    endfunction

    function automatic spec_out_t close_spec(logic [7:0] c);
        spec_out_t r;
        r.alt_form    = ps_flags[FB_HASH];
        r.zero_pad    = ps_flags[FB_ZERO];
        r.left_align  = ps_flags[FB_DASH];
        r.space_sign  = ps_flags[FB_SPACE];
        r.plus_sign   = ps_flags[FB_PLUS];
        r.width_given = ps_given[GB_WIDTH];
        r.field_width = ps_width[30:0];
        r.prec_given  = ps_given[GB_PREC];
        r.prec_value  = ps_prec[30:0];
        r.length_code = ps_len;
        r.stop_char   = c;
        clear_parser();
        return r;
    endfunction

    // Advances the tracked state by one character; returns 1 when the spec ends.
    function automatic bit parse_char(input spec_in_t it, output spec_out_t res);
        logic [7:0]      c;
        logic [31:0]     sv;
        logic [31:0]     neg_sv;
        bit              neg;
        longint unsigned mag;
        logic [4:0]      fbit;
        c = it.spec_char;
        sv = it.star_value;
        neg = sv[31];
        neg_sv = ~sv + 32'd1;
        mag = neg ? {32'd0, neg_sv} : {32'd0, sv};
        if (mag > ACC_MAX)
            mag = ACC_MAX;
        res = '0;
        if (it.start_spec)
            clear_parser();

        if (ps_phase == PH_LEN_H || ps_phase == PH_LEN_L)
        begin
            if (c == ((ps_phase == PH_LEN_H) ? CH_LOW_H : CH_LOW_L))
            begin
                ps_len = (ps_phase == PH_LEN_H) ? LEN_HH : LEN_LL;
                ps_phase = PH_LEN_DONE;
                return 1'b0;
            end
            ps_len = (ps_phase == PH_LEN_H) ? LEN_H : LEN_L;
            res = close_spec(c);
            return 1'b1;
        end
        if (ps_phase == PH_LEN_DONE)
        begin
            res = close_spec(c);
            return 1'b1;
        end

        if (ps_phase == PH_FLAGS)
        begin
            fbit = '0;
            case (c)
                CH_HASH:  fbit[FB_HASH] = 1'b1;
                CH_ZERO:  fbit[FB_ZERO] = 1'b1;
                CH_DASH:  fbit[FB_DASH] = 1'b1;
                CH_SPACE: fbit[FB_SPACE] = 1'b1;
                CH_PLUS:  fbit[FB_PLUS] = 1'b1;
                default:  fbit = '0;
            endcase
            if (fbit != '0)
            begin
                ps_flags = ps_flags | fbit;
                if (ps_flags[FB_DASH])
                    ps_flags[FB_ZERO] = 1'b0;
                return 1'b0;
            end
            ps_phase = PH_WIDTH;
        end

        if (ps_phase == PH_WIDTH || ps_phase == PH_WIDTH_DIG)
        begin
            if (c == CH_STAR)
            begin
                // A negative width sets the dash flag but leaves zero alone.
                if (neg)
                    ps_flags[FB_DASH] = 1'b1;
                ps_width = mag;
                ps_given[GB_WIDTH] = 1'b1;
                ps_phase = PH_WIDTH;
                return 1'b0;
            end
            if (c >= CH_ZERO && c <= CH_NINE)
            begin
                if (ps_phase == PH_WIDTH)
                    ps_width = 0;
                ps_width = add_digit(ps_width, c);
                ps_given[GB_WIDTH] = 1'b1;
                ps_phase = PH_WIDTH_DIG;
                return 1'b0;
            end
            if (c == CH_DOT)
            begin
                ps_given[GB_PREC] = 1'b1;
                ps_prec = 0;
                ps_phase = PH_PREC_DOT;
                return 1'b0;
            end
        end
        else if (ps_phase == PH_PREC_DOT || ps_phase == PH_PREC_DIG)
        begin
            if (ps_phase == PH_PREC_DOT && c == CH_STAR)
            begin
                if (neg)
                    ps_given[GB_PREC] = 1'b0;
                else
                    ps_prec = mag;
                ps_phase = PH_PREC_DIG;
                return 1'b0;
            end
            if (c >= CH_ZERO && c <= CH_NINE)
            begin
                ps_prec = add_digit(ps_prec, c);
                ps_phase = PH_PREC_DIG;
                return 1'b0;
            end
        end

        case (c)
            CH_LOW_H:
            begin
                ps_phase = PH_LEN_H;
                return 1'b0;
            end
            CH_LOW_L:
            begin
                ps_phase = PH_LEN_L;
                return 1'b0;
            end
            CH_LOW_J:
            begin
                ps_len = LEN_J;
                ps_phase = PH_LEN_DONE;
                return 1'b0;
            end
            CH_LOW_Z:
            begin
                ps_len = LEN_Z;
                ps_phase = PH_LEN_DONE;
                return 1'b0;
            end
            CH_UP_L:
            begin
                ps_len = LEN_BIGL;
                ps_phase = PH_LEN_DONE;
                return 1'b0;
            end
            default:
                ps_len = ps_len;
        endcase

        res = close_spec(c);
        return 1'b1;
    endfunction

    function automatic logic [31:0] rand_star();
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'($urandom_range(0, 200)) - 32'd100;
            default: return $urandom;
        endcase
    endfunction

    function automatic void push_digits(int n);
        repeat (n) spec_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    endfunction

    function automatic dir_row_t char_row(bit st, logic [7:0] c, logic [31:0] sv);
        dir_row_t r;
        r = '0;
        r.item.start_spec = st;
        r.item.spec_char = c;
        r.item.star_value = sv;
        return r;
    endfunction

    function automatic dir_row_t end_row(bit st, logic [7:0] c, logic [4:0] flags,
                                         logic [1:0] given, logic [30:0] w,
                                         logic [30:0] p, length_t len);
        dir_row_t r;
        r = char_row(st, c, 32'd0);
        r.typed = 1'b1;
        r.want.alt_form    = flags[FB_HASH];
        r.want.zero_pad    = flags[FB_ZERO];
        r.want.left_align  = flags[FB_DASH];
        r.want.space_sign  = flags[FB_SPACE];
        r.want.plus_sign   = flags[FB_PLUS];
        r.want.width_given = given[GB_WIDTH];
        r.want.field_width = w;
        r.want.prec_given  = given[GB_PREC];
        r.want.prec_value  = p;
        r.want.length_code = len;
        r.want.stop_char   = c;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        n_mismatch = n_mismatch + 1;
        $display("%0t MISMATCH %s", $time, msg);
    endtask

    // Four-state compare, so an unknown output bit counts as a mismatch.
    task automatic cmp_field(input string name, input logic [63:0] got,
                             input logic [63:0] want, input logic [7:0] stop);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d want %0d (stop char %02h)",
                                      name, got, want, stop));
    endtask

    task automatic check_result(input spec_out_t got, input spec_out_t want);
        cmp_field("alt_form", got.alt_form, want.alt_form, want.stop_char);
        cmp_field("zero_pad", got.zero_pad, want.zero_pad, want.stop_char);
        cmp_field("left_align", got.left_align, want.left_align, want.stop_char);
        cmp_field("space_sign", got.space_sign, want.space_sign, want.stop_char);
        cmp_field("plus_sign", got.plus_sign, want.plus_sign, want.stop_char);
        cmp_field("width_given", got.width_given, want.width_given, want.stop_char);
        cmp_field("field_width", got.field_width, want.field_width, want.stop_char);
        cmp_field("prec_given", got.prec_given, want.prec_given, want.stop_char);
        cmp_field("prec_value", got.prec_value, want.prec_value, want.stop_char);
        cmp_field("length_code", got.length_code, want.length_code, want.stop_char);
        cmp_field("stop_char", got.stop_char, want.stop_char, want.stop_char);
    endtask

    // Offers one character and, once the transaction completes, predicts its result.
    task automatic send_char(input spec_in_t it, input bit typed, input spec_out_t want);
        spec_out_t pred;
        bit        has;
        int        gap;
        char_valid <= 1'b1;
        char_item <= it;
        @(posedge clk);
        while (!char_ready)
            @(posedge clk);
        has = parse_char(it, pred);
        if (has)
            parsed_specs_q.push_back(typed ? want : pred);
        n_sent = n_sent + 1;
        burst_left = burst_left - 1;
        if (burst_left <= 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                char_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
    endtask

    // Receiver: checks each result and stalls on its own pattern.
    initial
    begin
        int        mode;
        int        mode_left;
        int        hold_left;
        int        rx_cycle;
        spec_out_t want;
        mode = 0;
        mode_left = 0;
        hold_left = 0;
        rx_cycle = 0;
        forever
        begin
            @(posedge clk);
            rx_cycle = rx_cycle + 1;
            if (result_valid && result_ready)
            begin
                if (parsed_specs_q.size() == 0)
                    report_mismatch($sformatf("result with no spec pending (stop char %02h)",
                                              result_item.stop_char));
                else
                begin
                    want = parsed_specs_q.pop_front();
                    check_result(result_item, want);
                end
            end
            // One long hold-off so the parser fills up and stops taking characters.
            if (rx_cycle == HOLD_AT)
                hold_left = HOLD_LEN;
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 200);
            end
            mode_left = mode_left - 1;
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                result_ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0:       result_ready <= 1'b1;
                    1:       result_ready <= 1'($urandom_range(0, 1));
                    default: result_ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count = cycle_count + 1;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    initial
    begin
        spec_in_t it;
        bit       noise;
        bit       first_start;
        rst_n <= 1'b0;
        char_valid <= 1'b0;
        char_item <= '0;
        result_ready <= 1'b0;
        clear_parser();
        burst_left = $urandom_range(1, 40);

        dir_rows = '{
            end_row(1'b1, "d", 5'd0, 2'd0, 31'd0, 31'd0, LEN_NONE),
            char_row(1'b1, CH_ZERO, 32'd0),
            char_row(1'b0, CH_STAR, 32'hFFFF_FFFD),
            end_row(1'b0, "d", M_ZERO | M_DASH, G_WIDTH, 31'd3, 31'd0, LEN_NONE),
            char_row(1'b1, CH_DASH, 32'd0),
            char_row(1'b0, CH_HASH, 32'd0),
            char_row(1'b0, CH_SPACE, 32'd0),
            char_row(1'b0, CH_PLUS, 32'd0),
            char_row(1'b0, CH_ZERO, 32'd0),
            char_row(1'b0, CH_STAR, 32'h8000_0000),
            char_row(1'b0, CH_DOT, 32'd0),
            char_row(1'b0, CH_STAR, 32'h7FFF_FFFF),
            char_row(1'b0, CH_LOW_L, 32'd0),
            char_row(1'b0, CH_LOW_L, 32'd0),
            end_row(1'b0, "x", M_HASH | M_DASH | M_SPACE | M_PLUS, G_WIDTH | G_PREC,
                    31'h7FFF_FFFF, 31'h7FFF_FFFF, LEN_LL),
            char_row(1'b1, "5", 32'd0),
            char_row(1'b0, CH_STAR, 32'd9),
            char_row(1'b0, "2", 32'd0),
            char_row(1'b0, CH_DOT, 32'd0),
            char_row(1'b0, CH_STAR, 32'hFFFF_FFFF),
            char_row(1'b0, "4", 32'd0),
            char_row(1'b0, CH_LOW_H, 32'd0),
            char_row(1'b0, 8'h00, 32'd0),
            char_row(1'b1, CH_LOW_Z, 32'd0),
            end_row(1'b0, 8'hFF, 5'd0, 2'd0, 31'd0, 31'd0, LEN_Z)
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_DIR; i++)
            send_char(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

        while (n_sent < N_DIR + N_RANDOM)
        begin
            spec_bytes.delete();
            noise = ($urandom_range(0, 9) == 0);
            if (noise)
            begin
                repeat ($urandom_range(1, 6)) spec_bytes.push_back(8'($urandom_range(0, 255)));
                first_start = 1'($urandom_range(0, 1));
            end
            else
            begin
                first_start = ($urandom_range(0, 9) < 7);
                repeat ($urandom_range(0, 3))
                    spec_bytes.push_back(flag_chars[$urandom_range(0, 4)]);
                case ($urandom_range(0, 5))
                    1: push_digits($urandom_range(1, 3));
                    2: spec_bytes.push_back(CH_STAR);
                    3:
                    begin
                        spec_bytes.push_back(CH_STAR);
                        push_digits($urandom_range(1, 2));
                    end
                    4:
                    begin
                        push_digits($urandom_range(1, 2));
                        spec_bytes.push_back(CH_STAR);
                    end
                    5: push_digits($urandom_range(10, 12));
                    default: ;
                endcase
                if ($urandom_range(0, 1) == 1)
                begin
                    spec_bytes.push_back(CH_DOT);
                    case ($urandom_range(0, 4))
                        1: spec_bytes.push_back(CH_STAR);
                        2:
                        begin
                            spec_bytes.push_back(CH_STAR);
                            push_digits($urandom_range(1, 2));
                        end
                        3: push_digits($urandom_range(1, 3));
                        4: push_digits($urandom_range(10, 12));
                        default: ;
                    endcase
                end
                case ($urandom_range(0, 7))
                    1: spec_bytes.push_back(CH_LOW_H);
                    2:
                    begin
                        spec_bytes.push_back(CH_LOW_H);
                        spec_bytes.push_back(CH_LOW_H);
                    end
                    3: spec_bytes.push_back(CH_LOW_L);
                    4:
                    begin
                        spec_bytes.push_back(CH_LOW_L);
                        spec_bytes.push_back(CH_LOW_L);
                    end
                    5: spec_bytes.push_back(CH_LOW_J);
                    6: spec_bytes.push_back(CH_LOW_Z);
                    7: spec_bytes.push_back(CH_UP_L);
                    default: ;
                endcase
                if ($urandom_range(0, 4) == 0)
                    spec_bytes.push_back(8'($urandom_range(0, 255)));
                else
                    spec_bytes.push_back(conv_chars[$urandom_range(0, conv_chars.len() - 1)]);
            end
            foreach (spec_bytes[i])
            begin
                // Now and then a new spec is started in the middle of one.
                if (i == 0)
                    it.start_spec = first_start;
                else
                    it.start_spec = noise ? ($urandom_range(0, 3) == 0)
                                          : ($urandom_range(0, 49) == 0);
                it.spec_char = spec_bytes[i];
                it.star_value = rand_star();
                send_char(it, 1'b0, '0);
            end
        end

        char_valid <= 1'b0;
        while (parsed_specs_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (n_mismatch == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
